>>> rtl/core/trwm_pkg.sv
package trwm_pkg;

	localparam int NUM_IFACES      = 16;
	localparam int SLOTS_PER_IFACE = 900;
	localparam int SLOT_DEPTH      = NUM_IFACES * SLOTS_PER_IFACE;
	localparam int ADDR_W          = $clog2(SLOT_DEPTH);
	localparam int IDX_W           = $clog2(SLOTS_PER_IFACE);
	localparam int CNT_W           = $clog2(SLOTS_PER_IFACE + 1);
	localparam int IFACE_W         = 4;
	localparam int TIME_W          = 31;
	localparam int CNT64_W         = 64;
	localparam int WIN_W           = 16;
	localparam int NUM_WIN         = 3;
	localparam int NUM_RATES       = 6;
	localparam int CFG_IDX_W       = 2;

	localparam logic [CFG_IDX_W-1:0] CFG_WIN_SHORT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_WIN_MID   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_WIN_LONG  = 2'd2;

	localparam logic [WIN_W-1:0] WIN_SHORT_RST = 16'd60;
	localparam logic [WIN_W-1:0] WIN_MID_RST   = 16'd300;
	localparam logic [WIN_W-1:0] WIN_LONG_RST  = 16'd900;

	typedef struct packed {
		logic [CNT64_W-1:0] recv;
		logic [CNT64_W-1:0] sent;
		logic [TIME_W-1:0]  tstamp;
	} slot_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

	typedef enum logic [3:0] {
		ST_INIT,
		ST_IDLE,
		ST_SCAN1,
		ST_CLR,
		ST_INS,
		ST_SCAN2,
		ST_SCAN3,
		ST_DIV,
		ST_FIN
	} state_t;

endpackage

>>> rtl/core/traffic_rate_window_meter_core.sv
// per-interface traffic rate meter over three sliding windows. one counter sample is
// taken at a time and s_tready stays low until its result is registered. a sample makes
// up to three passes over the interface's slots through the single slot memory port,
// plus up to six passes of the shared bit-serial divider. a counter drop empties the
// interface with a write sweep over its slots. after reset a clearing pass over all
// NUM_IFACES * SLOTS_PER_IFACE slots (14400) runs before the first request is taken.
module traffic_rate_window_meter_core
	import trwm_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [159:0]         s_tdata,   // now[30:0], sent_count[94:31], recv_count[158:95]
	input  logic [IFACE_W-1:0]   s_tuser,   // iface[3:0]
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [383:0]         m_tdata,   // out_rate_short, out_rate_mid, out_rate_long,
	                                        // in_rate_short, in_rate_mid, in_rate_long
	output logic                 m_tuser,   // history_cleared
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_idx,
	input  logic [WIN_W-1:0]     cfg_wdata
);

	state_t state_q, state_d;

	logic [WIN_W-1:0]   win_q [NUM_WIN];
	logic [ADDR_W-1:0]  init_q;
	logic [ADDR_W-1:0]  base_q;
	logic [CNT_W-1:0]   j_q;
	logic               rd_vld_s1;
	logic [IDX_W-1:0]   rd_idx_s1;
	logic [TIME_W-1:0]  now_q;
	logic [CNT64_W-1:0] snt_q, rcv_q;
	logic               bounce_q, free_q;
	logic [IDX_W-1:0]   free_idx_q;
	logic [TIME_W-1:0]  best_q [NUM_WIN];
	logic               have_q [NUM_WIN];
	logic [CNT64_W-1:0] es_q [NUM_WIN];
	logic [CNT64_W-1:0] er_q [NUM_WIN];
	logic [CNT64_W-1:0] cs_q, cr_q;
	logic               have_cur_q;
	logic [2:0]         op_q;
	logic               dv_run_q;
	logic [CNT64_W-1:0] rate_q [NUM_RATES];
	logic               cleared_q;
	logic               m_tvalid_q;
	logic [383:0]       m_tdata_q;
	logic               m_tuser_q;

	logic [ADDR_W-1:0]  ram_addr;
	logic               ram_we;
	slot_t              ram_wdata, rd;
	logic               rd_issue;
	logic               scan_done;
	logic               in_bad;
	logic               out_free;
	logic               win_ok [NUM_WIN];
	logic               free_hit, bounce_hit;
	logic [1:0]         op_k;
	logic               op_sent;
	logic [CNT64_W-1:0] cur_sel, old_sel;
	logic               op_ok;
	logic               div_start;
	logic [CNT64_W-1:0] div_quo;
	div_stat_t          div_stat;
	logic [WIN_W-1:0]   span;

	trwm_ram #(
		.DEPTH (SLOT_DEPTH),
		.WIDTH ($bits(slot_t)),
		.AW    (ADDR_W)
	) u_ram (
		.clk   (clk),
		.addr  (ram_addr),
		.we    (ram_we),
		.wdata (ram_wdata),
		.rdata (rd)
	);

	trwm_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (cur_sel - old_sel),
		.divisor  (span),
		.quotient (div_quo),
		.stat     (div_stat)
	);

	assign in_bad    = ({1'b0, s_tuser} >= (IFACE_W + 1)'(NUM_IFACES)) ||
	                   (s_tdata[TIME_W-1:0] == '0);
	assign scan_done = (j_q == CNT_W'(SLOTS_PER_IFACE)) && !rd_vld_s1;
	assign out_free  = !m_tvalid_q || m_tready;

	always_comb begin
		for (int k = 0; k < NUM_WIN; k++) begin
			win_ok[k] = ({1'b0, rd.tstamp} + 32'(win_q[k])) >= {1'b0, now_q};
		end
		free_hit   = ({1'b0, rd.tstamp} + 32'(win_q[2])) < {1'b0, now_q};
		bounce_hit = (rd.tstamp < now_q) && ((snt_q < rd.sent) || (rcv_q < rd.recv));
	end

	always_comb begin
		op_sent = op_q < 3'd3;
		op_k    = op_sent ? op_q[1:0] : 2'(op_q - 3'd3);
		cur_sel = op_sent ? cs_q : cr_q;
		old_sel = op_sent ? es_q[op_k] : er_q[op_k];
		op_ok   = have_cur_q && have_q[op_k] && (cur_sel != '0) && (old_sel != '0) &&
		          (cur_sel >= old_sel);
		span    = WIN_W'(now_q - best_q[op_k]);
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_INIT: begin
				if (init_q == ADDR_W'(SLOT_DEPTH - 1)) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (s_tvalid) state_d = in_bad ? ST_FIN : ST_SCAN1;
			end
			ST_SCAN1: begin
				if (scan_done) begin
					if (bounce_q)    state_d = ST_CLR;
					else if (free_q) state_d = ST_INS;
					else             state_d = ST_SCAN2;
				end
			end
			ST_CLR: begin
				if (j_q == CNT_W'(SLOTS_PER_IFACE - 1)) state_d = ST_FIN;
			end
			ST_INS:   state_d = ST_SCAN2;
			ST_SCAN2: begin
				if (scan_done) state_d = ST_SCAN3;
			end
			ST_SCAN3: begin
				if (scan_done) state_d = ST_DIV;
			end
			ST_DIV: begin
				if (op_q == 3'(NUM_RATES)) state_d = ST_FIN;
			end
			ST_FIN: begin
				if (out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		s_tready  = 1'b0;
		ram_we    = 1'b0;
		ram_addr  = base_q + ADDR_W'(j_q);
		ram_wdata = '0;
		rd_issue  = 1'b0;
		div_start = 1'b0;
		unique case (state_q)
			ST_INIT: begin
				ram_we   = 1'b1;
				ram_addr = init_q;
			end
			ST_IDLE:  s_tready = 1'b1;
			ST_CLR:   ram_we   = 1'b1;
			ST_INS: begin
				ram_we    = 1'b1;
				ram_addr  = base_q + ADDR_W'(free_idx_q);
				ram_wdata = '{recv: rcv_q, sent: snt_q, tstamp: now_q};
			end
			ST_SCAN1, ST_SCAN2, ST_SCAN3: begin
				rd_issue = j_q < CNT_W'(SLOTS_PER_IFACE);
			end
			ST_DIV: begin
				div_start = (op_q < 3'(NUM_RATES)) && !dv_run_q && op_ok;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_INIT;
			init_q     <= '0;
			j_q        <= '0;
			rd_vld_s1  <= 1'b0;
			op_q       <= '0;
			dv_run_q   <= 1'b0;
			m_tvalid_q <= 1'b0;
			win_q[0]   <= WIN_SHORT_RST;
			win_q[1]   <= WIN_MID_RST;
			win_q[2]   <= WIN_LONG_RST;
		end else begin
			state_q   <= state_d;
			rd_vld_s1 <= rd_issue;
			if (cfg_we) begin
				unique case (cfg_idx)
					CFG_WIN_SHORT: win_q[0] <= cfg_wdata;
					CFG_WIN_MID:   win_q[1] <= cfg_wdata;
					CFG_WIN_LONG:  win_q[2] <= cfg_wdata;
					default: ;
				endcase
			end
			if (state_q == ST_INIT) init_q <= init_q + 1'b1;
			if (state_d != state_q) begin
				j_q <= '0;
			end else if (rd_issue || state_q == ST_CLR) begin
				j_q <= j_q + 1'b1;
			end
			if (state_q == ST_IDLE) begin
				op_q     <= '0;
				dv_run_q <= 1'b0;
			end else if (state_q == ST_DIV && op_q < 3'(NUM_RATES)) begin
				if (!dv_run_q) begin
					if (op_ok) dv_run_q <= 1'b1;
					else       op_q     <= op_q + 1'b1;
				end else if (div_stat.done) begin
					dv_run_q <= 1'b0;
					op_q     <= op_q + 1'b1;
				end
			end
			if (state_q == ST_FIN && out_free) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tvalid_q && m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		rd_idx_s1 <= j_q[IDX_W-1:0];
		if (state_q == ST_IDLE && s_tvalid) begin
			base_q     <= ADDR_W'(s_tuser) * ADDR_W'(SLOTS_PER_IFACE);
			now_q      <= s_tdata[30:0];
			snt_q      <= s_tdata[94:31];
			rcv_q      <= s_tdata[158:95];
			bounce_q   <= 1'b0;
			free_q     <= 1'b0;
			have_cur_q <= 1'b0;
			cleared_q  <= 1'b0;
			for (int k = 0; k < NUM_WIN; k++) begin
				have_q[k] <= 1'b0;
				es_q[k]   <= '0;
				er_q[k]   <= '0;
			end
			for (int r = 0; r < NUM_RATES; r++) begin
				rate_q[r] <= '0;
			end
		end
		if (rd_vld_s1) begin
			unique case (state_q)
				ST_SCAN1: begin
					if (bounce_hit) bounce_q <= 1'b1;
					if (!free_q && free_hit) begin
						free_q     <= 1'b1;
						free_idx_q <= rd_idx_s1;
					end
				end
				ST_SCAN2: begin
					if (rd.tstamp != '0 && rd.tstamp < now_q) begin
						for (int k = 0; k < NUM_WIN; k++) begin
							if (win_ok[k] && (!have_q[k] || rd.tstamp < best_q[k])) begin
								best_q[k] <= rd.tstamp;
								have_q[k] <= 1'b1;
							end
						end
					end
				end
				ST_SCAN3: begin
					if (rd.tstamp == now_q) begin
						cs_q       <= rd.sent;
						cr_q       <= rd.recv;
						have_cur_q <= 1'b1;
					end
					for (int k = 0; k < NUM_WIN; k++) begin
						if (have_q[k] && rd.tstamp == best_q[k]) begin
							es_q[k] <= rd.sent;
							er_q[k] <= rd.recv;
						end
					end
				end
				default: ;
			endcase
		end
		if (state_q == ST_CLR) cleared_q <= 1'b1;
		if (state_q == ST_DIV && op_q < 3'(NUM_RATES) && dv_run_q && div_stat.done) begin
			rate_q[op_q] <= div_quo;
		end
		if (state_q == ST_FIN && out_free) begin
			m_tdata_q <= {rate_q[5], rate_q[4], rate_q[3], rate_q[2], rate_q[1], rate_q[0]};
			m_tuser_q <= cleared_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

endmodule

>>> rtl/core/trwm_ram.sv
module trwm_ram #(
	parameter int DEPTH = 16,
	parameter int WIDTH = 8,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic [AW-1:0]    addr,
	input  logic             we,
	input  logic [WIDTH-1:0] wdata,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end

endmodule

>>> rtl/core/trwm_div.sv
module trwm_div
	import trwm_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [CNT64_W-1:0] dividend,
	input  logic [WIN_W-1:0]   divisor,
	output logic [CNT64_W-1:0] quotient,
	output div_stat_t          stat
);

	localparam int STEP_W = $clog2(CNT64_W);

	logic [CNT64_W-1:0] quo_q;
	logic [WIN_W-1:0]   rem_q;
	logic [WIN_W-1:0]   dvs_q;
	logic [STEP_W-1:0]  step_q;
	logic               busy_q;
	logic               done_q;
	logic [WIN_W:0]     rem_sh;
	logic               take;
	logic [WIN_W:0]     rem_nx;

	always_comb begin
		rem_sh = {rem_q, quo_q[CNT64_W-1]};
		take   = rem_sh >= {1'b0, dvs_q};
		rem_nx = take ? (rem_sh - {1'b0, dvs_q}) : rem_sh;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 1'b1;
				if (step_q == STEP_W'(CNT64_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[CNT64_W-2:0], take};
			rem_q <= rem_nx[WIN_W-1:0];
		end
	end

	assign quotient  = quo_q;
	assign stat.busy = busy_q;
	assign stat.done = done_q;

endmodule

>>> dv/tb_traffic_rate_window_meter_core.sv
module tb_traffic_rate_window_meter_core;
	import trwm_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	logic                 clk;
	logic                 arst_n;
	logic                 s_tvalid;
	logic                 s_tready;
	logic [159:0]         s_tdata;
	logic [IFACE_W-1:0]   s_tuser;
	logic                 m_tvalid;
	logic                 m_tready;
	logic [383:0]         m_tdata;
	logic                 m_tuser;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_idx;
	logic [WIN_W-1:0]     cfg_wdata;

	traffic_rate_window_meter_core u_dut (.*);

	typedef struct {
		bit [63:0] rate[NUM_RATES];
		bit        cleared;
	} rates_t;

	class rate_scoreboard;
		bit [TIME_W-1:0]  slot_tm[NUM_IFACES][SLOTS_PER_IFACE];
		bit [CNT64_W-1:0] slot_tx[NUM_IFACES][SLOTS_PER_IFACE];
		bit [CNT64_W-1:0] slot_rx[NUM_IFACES][SLOTS_PER_IFACE];
		bit [63:0]        win[NUM_WIN];
		rates_t           pending[$];
		int               errors;
		int               results;
		int               clears;

		function new();
			foreach (slot_tm[i, j]) begin
				slot_tm[i][j] = '0;
				slot_tx[i][j] = '0;
				slot_rx[i][j] = '0;
			end
			win[0] = WIN_SHORT_RST;
			win[1] = WIN_MID_RST;
			win[2] = WIN_LONG_RST;
		endfunction

		function void set_window(logic [CFG_IDX_W-1:0] idx, bit [WIN_W-1:0] val);
			case (idx)
				CFG_WIN_SHORT: win[0] = val;
				CFG_WIN_MID:   win[1] = val;
				CFG_WIN_LONG:  win[2] = val;
				default: ;
			endcase
		endfunction

		function bit [63:0] per_second(bit [63:0] cur, bit [63:0] old, bit [63:0] span);
			if (cur == 0 || old == 0 || cur < old || span == 0)
				return 0;
			return (cur - old) / span;
		endfunction

		function void note_sample(int ifc, bit [TIME_W-1:0] now_t, bit [63:0] tx,
		                          bit [63:0] rx);
			rates_t    e;
			bit [63:0] now;
			bit [63:0] t;
			bit [63:0] oldest[NUM_WIN];
			bit        found[NUM_WIN];
			bit [63:0] end_tx[NUM_WIN];
			bit [63:0] end_rx[NUM_WIN];
			bit [63:0] cur_tx;
			bit [63:0] cur_rx;
			bit        have_cur;
			bit        dropped;
			now = 64'(now_t);
			have_cur = 0;
			dropped = 0;
			cur_tx = 0;
			cur_rx = 0;
			foreach (e.rate[k])
				e.rate[k] = 0;
			e.cleared = 0;
			for (int k = 0; k < NUM_WIN; k++) begin
				oldest[k] = 0;
				found[k] = 0;
				end_tx[k] = 0;
				end_rx[k] = 0;
			end
			if (now == 0) begin
				pending.push_back(e);
				return;
			end
			for (int j = 0; j < SLOTS_PER_IFACE; j++)
				if (slot_tm[ifc][j] < now && (tx < slot_tx[ifc][j] || rx < slot_rx[ifc][j]))
					dropped = 1;
			if (dropped) begin
				for (int j = 0; j < SLOTS_PER_IFACE; j++) begin
					slot_tm[ifc][j] = 0;
					slot_tx[ifc][j] = 0;
					slot_rx[ifc][j] = 0;
				end
				e.cleared = 1;
				clears++;
				pending.push_back(e);
				return;
			end
			for (int j = 0; j < SLOTS_PER_IFACE; j++) begin
				t = 64'(slot_tm[ifc][j]);
				if (t + win[2] < now) begin
					slot_tm[ifc][j] = now_t;
					slot_tx[ifc][j] = tx;
					slot_rx[ifc][j] = rx;
					break;
				end
			end
			for (int j = 0; j < SLOTS_PER_IFACE; j++) begin
				t = 64'(slot_tm[ifc][j]);
				if (t != 0 && t < now)
					for (int k = 0; k < NUM_WIN; k++)
						if (t + win[k] >= now && (!found[k] || t < oldest[k])) begin
							oldest[k] = t;
							found[k] = 1;
						end
			end
			for (int j = 0; j < SLOTS_PER_IFACE; j++) begin
				t = 64'(slot_tm[ifc][j]);
				if (t == now) begin
					cur_tx = slot_tx[ifc][j];
					cur_rx = slot_rx[ifc][j];
					have_cur = 1;
				end
				for (int k = 0; k < NUM_WIN; k++)
					if (found[k] && t == oldest[k]) begin
						end_tx[k] = slot_tx[ifc][j];
						end_rx[k] = slot_rx[ifc][j];
					end
			end
			if (have_cur)
				for (int k = 0; k < NUM_WIN; k++)
					if (found[k]) begin
						e.rate[k] = per_second(cur_tx, end_tx[k], now - oldest[k]);
						e.rate[3+k] = per_second(cur_rx, end_rx[k], now - oldest[k]);
					end
			pending.push_back(e);
		endfunction

		task report(string msg);
			$display("mismatch at %0t: %s", $realtime, msg);
			errors++;
		endtask

		task check_result(bit [383:0] d, bit clr);
			rates_t e;
			string  names[NUM_RATES] = '{"out_rate_short", "out_rate_mid", "out_rate_long",
			                             "in_rate_short", "in_rate_mid", "in_rate_long"};
			results++;
			if (pending.size() == 0) begin
				report("result with no request outstanding");
				return;
			end
			e = pending.pop_front();
			for (int k = 0; k < NUM_RATES; k++)
				if (d[64*k +: 64] !== e.rate[k])
					report($sformatf("%s got %0d want %0d", names[k], d[64*k +: 64], e.rate[k]));
			if (clr !== e.cleared)
				report($sformatf("history_cleared got %0b want %0b", clr, e.cleared));
		endtask
	endclass

	rate_scoreboard sb;
	bit             rx_idle_on;
	int             sent_items;
	bit [TIME_W-1:0] ifc_time[NUM_IFACES];
	bit [63:0]       ifc_tx[NUM_IFACES];
	bit [63:0]       ifc_rx[NUM_IFACES];

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	initial begin
		#40ms;
		$display("timeout waiting for results");
		$display("tb_traffic_rate_window_meter_core: errors");
		$finish;
	end

	// entered and left at a falling edge
	task automatic send_sample(int ifc, bit [TIME_W-1:0] now, bit [63:0] tx, bit [63:0] rx,
	                           bit with_gap = 1);
		int gap;
		gap = with_gap ? $urandom_range(0, 16) : 0;
		if (gap > 0) begin
			s_tvalid = 0;
			repeat (gap) @(negedge clk);
		end
		s_tdata = {1'b0, rx, tx, now};
		s_tuser = ifc[IFACE_W-1:0];
		s_tvalid = 1;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		sb.note_sample(ifc, now, tx, rx);
		sent_items++;
		@(negedge clk);
		s_tvalid = 0;
	endtask

	task automatic write_window(logic [CFG_IDX_W-1:0] idx, bit [WIN_W-1:0] val);
		cfg_we = 1;
		cfg_idx = idx;
		cfg_wdata = val;
		@(negedge clk);
		cfg_we = 0;
		sb.set_window(idx, val);
	endtask

	task automatic drain();
		while (sb.pending.size() != 0)
			@(negedge clk);
		repeat (20) @(negedge clk);
	endtask

	task automatic set_windows(bit [WIN_W-1:0] ws, bit [WIN_W-1:0] wm, bit [WIN_W-1:0] wl);
		drain();
		write_window(CFG_WIN_SHORT, ws);
		write_window(CFG_WIN_MID, wm);
		write_window(CFG_WIN_LONG, wl);
	endtask

	// mostly steady counter streams per interface, with noise and counter restarts
	task automatic run_stream(int n, int max_step);
		int        ifc;
		int        pick;
		bit [63:0] tx;
		bit [63:0] rx;
		for (int i = 0; i < n; i++) begin
			ifc = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : $urandom_range(0, 3);
			pick = $urandom_range(0, 19);
			if (pick == 0) begin
				send_sample(ifc, TIME_W'($urandom),
				            {$urandom, $urandom}, {$urandom, $urandom});
			end else if (pick == 1) begin
				ifc_time[ifc] += TIME_W'($urandom_range(1, 3));
				ifc_tx[ifc] = ifc_tx[ifc] >> $urandom_range(1, 8);
				ifc_rx[ifc] = ifc_rx[ifc] - 64'($urandom_range(0, 1));
				send_sample(ifc, ifc_time[ifc], ifc_tx[ifc], ifc_rx[ifc]);
			end else begin
				ifc_time[ifc] += TIME_W'($urandom_range(0, max_step));
				tx = ($urandom_range(0, 9) == 0) ? {$urandom, 32'h0} :
				     64'($urandom_range(0, 2000000));
				rx = 64'($urandom_range(0, 5000000));
				ifc_tx[ifc] += tx;
				ifc_rx[ifc] += rx;
				send_sample(ifc, ifc_time[ifc], ifc_tx[ifc], ifc_rx[ifc],
				            rx_idle_on);
			end
		end
	endtask

	initial begin
		sb = new();
		arst_n = 0;
		s_tvalid = 0;
		s_tdata = '0;
		s_tuser = '0;
		m_tready = 0;
		cfg_we = 0;
		cfg_idx = CFG_WIN_SHORT;
		cfg_wdata = '0;
		rx_idle_on = 1;
		sent_items = 0;
		for (int i = 0; i < NUM_IFACES; i++) begin
			ifc_time[i] = TIME_W'($urandom_range(1000, 32'h7FF0_0000));
			ifc_tx[i] = {$urandom_range(0, 32'h3FFF_FFFF), $urandom};
			ifc_rx[i] = {$urandom_range(0, 32'h3FFF_FFFF), $urandom};
		end
		ifc_time[3] = 31'h7FF0_0000;
		repeat (10) @(negedge clk);
		arst_n = 1;
		@(negedge clk);

		// defaults, directed corners
		send_sample(0, 0, 64'd5, 64'd5);
		send_sample(5, 100, 0, 0);
		send_sample(5, 101, 1000, 2000);
		send_sample(5, 101, 1500, 2500);
		send_sample(5, 103, 9000, 9000);
		send_sample(5, 400, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
		send_sample(5, 401, 64'hFFFF_FFFF_FFFF_FFFF, 64'd7);
		send_sample(5, 402, 64'd5, 64'd5);
		send_sample(6, 31'h7FFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
		send_sample(6, 31'h7FFF_FFFE, 64'd1, 64'd1);
		send_sample(6, 31'h7FFF_FFFF, 64'd2, 64'd2);
		send_sample(7, 1, 64'd1, 64'd1);
		send_sample(7, 61, 64'd601, 64'd121);
		send_sample(7, 62, 64'd700, 64'd200);
		run_stream(50, 3);

		// short windows so slots age out and get reused
		set_windows(1, 5, 10);
		rx_idle_on = 0;
		run_stream(30, 3);
		rx_idle_on = 1;
		run_stream(40, 4);

		// zero and widest windows
		set_windows(0, 16'hFFFF, 16'hFFFF);
		send_sample(8, 10, 100, 100);
		send_sample(8, 10, 200, 200);
		send_sample(8, 65545, 65635, 131172);
		run_stream(35, 2000);

		set_windows(16'hFFFF, 2, 1);
		run_stream(35, 2);

		drain();
		repeat (50) @(negedge clk);
		$display("%0d requests and %0d results over four window settings, %0d history clears",
		         sent_items, sb.results, sb.clears);
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("tb_traffic_rate_window_meter_core: clean");
		else
			$display("tb_traffic_rate_window_meter_core: errors");
		$finish;
	end

	// result side, with one long hold-off so the input backs up
	initial begin
		int gap;
		int taken;
		taken = 0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			gap = rx_idle_on ? $urandom_range(0, 16) : 0;
			if (taken == 40)
				gap = 12000;
			m_tready = 0;
			repeat (gap) @(negedge clk);
			m_tready = 1;
			@(posedge clk);
			while (!m_tvalid)
				@(posedge clk);
			sb.check_result(m_tdata, m_tuser);
			taken++;
			@(negedge clk);
		end
	end

endmodule
